@@ rtl/core/vbap_pkg.sv @@
// ---------------------------------------------------------------------------
// VBAP gain selection package
// Shared types, constants and codes for the gain selection block.
// ---------------------------------------------------------------------------
package vbap_pkg;

   // Input word modes.
   localparam logic [1:0] MODE_COEF  = 2'd0;
   localparam logic [1:0] MODE_SPK   = 2'd1;
   localparam logic [1:0] MODE_SGAIN = 2'd2;
   localparam logic [1:0] MODE_PAN   = 2'd3;

   // Register indexes.
   localparam logic REG_DIMENSION   = 1'b0;
   localparam logic REG_GROUP_COUNT = 1'b1;

   // Selection floor of -0.01 in units of 2^-27.
   localparam logic signed [35:0] GAIN_FLOOR = -36'sd1342178;
   localparam logic [15:0] UNITY = 16'd32768;

   typedef struct packed {
      logic [1:0]         mode;
      logic [3:0]         index;
      logic [3:0]         slot;
      logic signed [15:0] value;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic [15:0]        source_gain;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [3:0]  speaker_a;
      logic [3:0]  speaker_b;
      logic [3:0]  speaker_c;
      logic [15:0] gain_a;
      logic [15:0] gain_b;
      logic [15:0] gain_c;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOAD, ST_SETUP, ST_MAC, ST_CMP, ST_NORM,
      ST_SQRT, ST_SCALE, ST_DIV, ST_NEXT, ST_DONE
   } state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic load;      // perform table write
      logic setup;     // latch vector, clear search
      logic mac;       // wait for read or multiply-accumulate
      logic cmp;       // compare group and advance
      logic norm;      // magnitudes and shift
      logic sqrt_step; // one sum-of-squares or square-root step
      logic scale;     // form numerator of one gain
      logic div_step;  // one multiply or division step
      logic next;      // store gain, next speaker
      logic done;      // emit result
   } cmd_type;

   typedef struct packed {
      logic mac_last;
      logic groups_done;
      logic have;
      logic sqrt_last;
      logic div_last;
      logic spk_last;
   } sts_type;

endpackage

@@ rtl/core/vbap_ctrl.sv @@
// ---------------------------------------------------------------------------
// VBAP controller
// Sequences table writes and the pan search, normalisation and division.
// ---------------------------------------------------------------------------
module vbap_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        mode,
   input  vbap_pkg::sts_type sts,
   output logic              busy,
   output vbap_pkg::cmd_type cmd
);
   import vbap_pkg::*;

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (mode == MODE_PAN) ? ST_SETUP : ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_IDLE;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_MAC;
         end
         ST_MAC: begin
            if (sts.groups_done) begin
               state_in = sts.have ? ST_NORM : ST_DONE;
            end else begin
               cmd.mac = 1'b1;
               if (sts.mac_last) begin
                  state_in = ST_CMP;
               end
            end
         end
         ST_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = ST_MAC;
         end
         ST_NORM: begin
            cmd.norm = 1'b1;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (sts.sqrt_last) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            cmd.next = 1'b1;
            state_in = sts.spk_last ? ST_DONE : ST_SCALE;
         end
         ST_DONE: begin
            cmd.done = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // A load never runs the pan sequence.
   a_load_short: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |=> state_ff == ST_IDLE)
      else $error("load word did not return to idle");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |=> state_ff == ST_IDLE)
      else $error("result not followed by idle");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one command at once");

endmodule

@@ rtl/core/vbap_dp.sv @@
// ---------------------------------------------------------------------------
// VBAP datapath
// Tables, group search with one multiplier, square root and gain division.
// ---------------------------------------------------------------------------
module vbap_dp #(
   parameter int MAX_GROUPS   = 16,
   parameter int MAX_SPEAKERS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  vbap_pkg::req_type req,
   input  logic              dimension,
   input  logic [4:0]        group_count,
   input  vbap_pkg::cmd_type cmd,
   output vbap_pkg::sts_type sts,
   output logic              rsp_strobe,
   output vbap_pkg::rsp_type rsp
);
   import vbap_pkg::*;

   localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int CD = MAX_GROUPS * 9;
   localparam int CW = $clog2(CD);
   localparam int SD = MAX_GROUPS * 3;
   localparam int SW = $clog2(SD);
   localparam int KW = $clog2(MAX_SPEAKERS);

   // Tables.
   logic signed [15:0] coef_mem [CD];
   logic [3:0]         spk_mem  [SD];
   logic [15:0]        gain_mem [MAX_SPEAKERS];

   req_type req_ff;
   logic signed [15:0] coef_rd_ff;
   logic [3:0]         spk_rd_ff;
   logic [15:0]        sgain_rd_ff;

   // Latch the word on acceptance.
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req;
      end
   end

   // Table writes, bounds checked against the parameters.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         case (req_ff.mode)
            MODE_COEF: begin
               if (32'(req_ff.index) < MAX_GROUPS && req_ff.slot <= 4'd8) begin
                  coef_mem[CW'(32'(req_ff.index) * 9 + 32'(req_ff.slot))] <= req_ff.value;
               end
            end
            MODE_SPK: begin
               if (32'(req_ff.index) < MAX_GROUPS && req_ff.slot <= 4'd2) begin
                  spk_mem[SW'(32'(req_ff.index) * 3 + 32'(req_ff.slot))] <=
                     req_ff.value[3:0];
               end
            end
            MODE_SGAIN: begin
               if (32'(req_ff.index) < MAX_SPEAKERS) begin
                  gain_mem[KW'(req_ff.index)] <= req_ff.value[15] ? 16'd0 : req_ff.value;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Search state.
   logic [1:0]  n_ff;
   logic signed [16:0] v_ff [3];
   logic [15:0] sg_ff;
   logic [GW:0] grp_ff, count_ff, chosen_ff;
   logic [1:0]  j_ff, k_ff;
   logic signed [35:0] acc_ff;
   logic signed [35:0] g_ff [3];
   logic signed [35:0] best_ff [3];
   logic signed [35:0] loud_ff;
   logic        have_ff;
   logic        rd_ok_ff;

   // Coefficient read address for the current product.
   logic [CW-1:0] coef_addr;
   logic [3:0]    jk;
   assign jk = 4'(j_ff * n_ff + {2'd0, k_ff});
   assign coef_addr = CW'(32'(grp_ff) * 9 + 32'(jk));

   // Registered read of the next coefficient.
   always_ff @(posedge clock) begin
      coef_rd_ff <= coef_mem[coef_addr];
   end

   logic signed [33:0] prod;
   assign prod = v_ff[k_ff] * coef_rd_ff;

   logic signed [35:0] low_g;
   always_comb begin
      low_g = (g_ff[0] < g_ff[1]) ? g_ff[0] : g_ff[1];
      if (n_ff == 2'd3 && g_ff[2] < low_g) begin
         low_g = g_ff[2];
      end
   end

   // Normalisation state.
   logic [35:0] mag_ff [3];
   logic [63:0] rem_ff, root_ff, bit_ff;
   logic [5:0]  sq_cnt_ff;
   logic [1:0]  s_ff;
   logic [65:0] num_ff;
   logic [65:0] quo_ff;
   logic [66:0] drem_ff;
   logic [6:0]  dcnt_ff;
   logic [15:0] gout_ff [3];
   logic [3:0]  spk_ff [3];
   logic [1:0]  mul_ph_ff;

   // Magnitudes, maximum and shift amounts.
   logic [35:0] m0, m1, m2, mmax;
   logic [5:0]  lz;
   always_comb begin
      m0 = best_ff[0][35] ? 36'(-best_ff[0]) : 36'(best_ff[0]);
      m1 = best_ff[1][35] ? 36'(-best_ff[1]) : 36'(best_ff[1]);
      m2 = (n_ff == 2'd3) ? (best_ff[2][35] ? 36'(-best_ff[2]) : 36'(best_ff[2])) : 36'd0;
      mmax = (m0 > m1) ? m0 : m1;
      if (m2 > mmax) begin
         mmax = m2;
      end
      lz = 6'd36;
      for (int b = 0; b < 36; b++) begin
         if (mmax[b]) begin
            lz = 6'(b);
         end
      end
   end

   // Shifted magnitude: top bit placed at 29.
   function automatic logic [35:0] shift_mag(input logic [35:0] m, input logic [5:0] top);
      logic [35:0] r;
      if (top >= 6'd29) begin
         r = m >> (top - 6'd29);
      end else begin
         r = m << (6'd29 - top);
      end
      return r;
   endfunction

   // Square of one shifted magnitude for the sum of squares.
   logic [1:0]  sq_sel;
   logic [29:0] sq_mag;
   logic [59:0] sq_prod;
   assign sq_sel  = (sq_cnt_ff < 6'd3) ? sq_cnt_ff[1:0] : 2'd0;
   assign sq_mag  = mag_ff[sq_sel][29:0];
   assign sq_prod = sq_mag * sq_mag;

   // Products that form the numerator of one gain.
   logic [45:0] scale_prod;
   logic [62:0] gain_prod;
   assign scale_prod = mag_ff[s_ff][29:0] * sg_ff;
   assign gain_prod  = num_ff[46:0] * sgain_rd_ff;

   // Divisor of the final gain.
   logic [66:0] divisor;
   assign divisor = {3'd0, root_ff} << 15;

   logic [66:0] dtrial;
   assign dtrial = {drem_ff[65:0], num_ff[65]};

   // Main sequencing registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= cmd.done;
         if (cmd.setup) begin
            n_ff  <= dimension ? 2'd3 : 2'd2;
            if (dimension) begin
               v_ff[0] <= 17'(req_ff.pos_x);
               v_ff[1] <= 17'(req_ff.pos_y);
               v_ff[2] <= 17'(req_ff.pos_z);
            end else begin
               v_ff[0] <= (req_ff.pos_z == 0 && req_ff.pos_x == 0) ? 17'sd1
                          : 17'(req_ff.pos_z);
               v_ff[1] <= -17'(req_ff.pos_x);
               v_ff[2] <= 17'sd0;
            end
            sg_ff    <= (req_ff.source_gain > UNITY) ? UNITY : req_ff.source_gain;
            count_ff <= (32'(group_count) > MAX_GROUPS) ? (GW+1)'(MAX_GROUPS)
                        : (GW+1)'(group_count);
            grp_ff   <= '0;
            j_ff     <= '0;
            k_ff     <= '0;
            acc_ff   <= '0;
            loud_ff  <= GAIN_FLOOR;
            have_ff  <= 1'b0;
            rd_ok_ff <= 1'b0;
            root_ff  <= '0;
            chosen_ff <= '0;
            for (int q = 0; q < 3; q++) begin
               best_ff[q] <= '0;
               g_ff[q] <= '0;
            end
         end
         if (cmd.mac) begin
            // Each product first waits for the registered read.
            if (!rd_ok_ff) begin
               rd_ok_ff <= 1'b1;
            end else begin
               rd_ok_ff <= 1'b0;
               if (k_ff == n_ff - 2'd1) begin
                  g_ff[j_ff] <= acc_ff + 36'(prod);
                  acc_ff <= '0;
                  k_ff <= '0;
                  j_ff <= (j_ff == n_ff - 2'd1) ? 2'd0 : j_ff + 2'd1;
               end else begin
                  acc_ff <= acc_ff + 36'(prod);
                  k_ff <= k_ff + 2'd1;
               end
            end
         end
         if (cmd.cmp) begin
            if (low_g > loud_ff) begin
               loud_ff   <= low_g;
               best_ff   <= g_ff;
               chosen_ff <= grp_ff;
               have_ff   <= 1'b1;
            end
            grp_ff <= grp_ff + 1'b1;
         end
         if (cmd.norm) begin
            mag_ff[0] <= shift_mag(m0, lz);
            mag_ff[1] <= shift_mag(m1, lz);
            mag_ff[2] <= shift_mag(m2, lz);
            rem_ff    <= '0;
            root_ff   <= '0;
            bit_ff    <= 64'd1 << 62;
            sq_cnt_ff <= '0;
            s_ff      <= '0;
            mul_ph_ff <= '0;
         end
         if (cmd.sqrt_step) begin
            // The sum of squares is formed first, then come 32 root steps.
            if (sq_cnt_ff < 6'd3) begin
               rem_ff <= rem_ff + 64'(sq_prod);
               sq_cnt_ff <= sq_cnt_ff + 6'd1;
            end else begin
               if (rem_ff >= root_ff + bit_ff) begin
                  rem_ff  <= rem_ff - (root_ff + bit_ff);
                  root_ff <= (root_ff >> 1) + bit_ff;
               end else begin
                  root_ff <= root_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               sq_cnt_ff <= sq_cnt_ff + 6'd1;
            end
            spk_rd_ff <= spk_mem[SW'(32'(chosen_ff) * 3)];
         end
         if (cmd.scale) begin
            spk_ff[s_ff] <= spk_rd_ff;
            num_ff  <= 66'(scale_prod);
            drem_ff <= '0;
            quo_ff  <= '0;
            dcnt_ff <= '0;
            mul_ph_ff <= 2'd0;
         end
         if (cmd.div_step) begin
            if (mul_ph_ff == 2'd0) begin
               num_ff <= 66'(gain_prod);
               mul_ph_ff <= 2'd1;
            end else begin
               num_ff <= {num_ff[64:0], 1'b0};
               if (dtrial >= divisor) begin
                  drem_ff <= dtrial - divisor;
                  quo_ff  <= {quo_ff[64:0], 1'b1};
               end else begin
                  drem_ff <= dtrial;
                  quo_ff  <= {quo_ff[64:0], 1'b0};
               end
               dcnt_ff <= dcnt_ff + 7'd1;
            end
         end
         if (cmd.next) begin
            if (!best_ff[s_ff][35] && best_ff[s_ff] != 0 && root_ff != 0) begin
               gout_ff[s_ff] <= (quo_ff > 66'(UNITY)) ? UNITY : quo_ff[15:0];
            end else begin
               gout_ff[s_ff] <= '0;
            end
            s_ff <= s_ff + 2'd1;
            // Fetch the next speaker of the group, if there is one.
            if (s_ff != n_ff - 2'd1) begin
               spk_rd_ff <= spk_mem[SW'(32'(chosen_ff) * 3 + 32'(s_ff) + 1)];
            end
         end
         if (cmd.done) begin
            if (have_ff && root_ff != 0) begin
               rsp.found     <= 1'b1;
               rsp.speaker_a <= spk_ff[0];
               rsp.speaker_b <= spk_ff[1];
               rsp.speaker_c <= (n_ff == 2'd3) ? spk_ff[2] : 4'd0;
               rsp.gain_a    <= gout_ff[0];
               rsp.gain_b    <= gout_ff[1];
               rsp.gain_c    <= (n_ff == 2'd3) ? gout_ff[2] : 16'd0;
            end else begin
               rsp <= '0;
            end
         end
      end
   end

   // Speaker gain read for the current speaker; out of range reads zero.
   always_ff @(posedge clock) begin
      sgain_rd_ff <= (32'(spk_rd_ff) < MAX_SPEAKERS) ? gain_mem[KW'(spk_rd_ff)] : 16'd0;
   end

   assign sts.mac_last    = rd_ok_ff && (k_ff == n_ff - 2'd1) && (j_ff == n_ff - 2'd1);
   assign sts.groups_done = (grp_ff >= count_ff);
   assign sts.have        = have_ff && (mmax != 0);
   assign sts.sqrt_last   = (sq_cnt_ff == 6'd34);
   assign sts.div_last    = (mul_ph_ff != 2'd0) && (dcnt_ff == 7'd65);
   assign sts.spk_last    = (s_ff == n_ff - 2'd1);

   // A result carries gains no larger than unity.
   a_gain_max: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp.gain_a <= UNITY && rsp.gain_b <= UNITY && rsp.gain_c <= UNITY)
      else $error("gain above unity");
   a_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp.found |-> rsp.gain_a == 0 && rsp.gain_b == 0)
      else $error("gains without a group");
   a_2d_c: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && n_ff == 2'd2 |-> rsp.gain_c == 0 && rsp.speaker_c == 0)
      else $error("third speaker set in plane mode");

endmodule

@@ rtl/core/vbap_gain_selection.sv @@
// ---------------------------------------------------------------------------
// VBAP gain selection
// Picks the speaker group for a source and returns its normalised gains.
// ---------------------------------------------------------------------------
// Channel  Ports                       Direction
// request  start, busy, req_word        in, one word when start && !busy
// result   rsp_strobe, rsp_word         out, one cycle, cannot be stalled
// csr      csr_psel .. csr_pready       APB, two registers
//
// A load word keeps busy high for one cycle after it is taken. A pan word takes
// a setup step, then for each searched group the products on one shared
// multiplier (registered coefficient read) and a compare, then a step to close
// the search. A found group then adds normalisation, the square root and, per
// speaker, scale, multiply, 66 division steps and store, then the result.
// Reset clears the controller and registers; tables are undefined until
// written. Results cannot be held off by the receiver.
// ---------------------------------------------------------------------------
module vbap_gain_selection #(
   parameter int MAX_GROUPS   = 16,
   parameter int MAX_SPEAKERS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  vbap_pkg::req_type req_word,
   output logic              rsp_strobe,
   output vbap_pkg::rsp_type rsp_word,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import vbap_pkg::*;

   logic       dimension_ff;
   logic [4:0] group_count_ff;
   cmd_type    cmd;
   sts_type    sts;

   assign csr_pready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         dimension_ff   <= 1'b0;
         group_count_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[1:0] == 2'd0) begin
         if (csr_paddr[2] == REG_DIMENSION) begin
            dimension_ff <= csr_pwdata[0];
         end else begin
            group_count_ff <= csr_pwdata[4:0];
         end
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[1:0] == 2'd0) begin
         if (csr_paddr[2] == REG_GROUP_COUNT) begin
            csr_prdata = 32'(group_count_ff);
         end else begin
            csr_prdata = 32'(dimension_ff);
         end
      end
   end

   vbap_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .mode  (req_word.mode),
      .sts   (sts),
      .busy  (busy),
      .cmd   (cmd)
   );

   vbap_dp #(
      .MAX_GROUPS   (MAX_GROUPS),
      .MAX_SPEAKERS (MAX_SPEAKERS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req         (req_word),
      .dimension   (dimension_ff),
      .group_count (group_count_ff),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_strobe  (rsp_strobe),
      .rsp         (rsp_word)
   );

endmodule
